/* rtl/nmit_pkg.sv */
// ----------------------------------------------------------------------------
// nmit_pkg: shared types and constants of the normal matrix unit
// Beat layouts, datapath widths, pipeline stage numbers and saturation codes.
// ----------------------------------------------------------------------------
package nmit_pkg;

    // Element and result widths.
    localparam int ELEM_W = 16;
    localparam int RES_W  = 32;
    localparam int THR_W  = 31;
    localparam int THR_RESET = 168;

    // Datapath widths.
    localparam int PROD_W  = 2 * ELEM_W;        // element product
    localparam int COF_W   = PROD_W + 1;        // cofactor
    localparam int DPROD_W = ELEM_W + COF_W;    // element times cofactor
    localparam int DET_W   = DPROD_W + 2;       // sum of three
    localparam int DMAG_W  = 48;                // |det| < 3 * 2^46
    localparam int CMAG_W  = PROD_W;            // |cof| <= 2^31
    localparam int NUM_SH  = 29;                // 2 * 2^28
    localparam int NUM_W   = CMAG_W + NUM_SH + 1;
    localparam int DEN_W   = DMAG_W + 1;
    localparam int QW      = RES_W;
    localparam int THR_SH  = 12;                // 2^-24 to 2^-36 units

    // Number of matrix elements, one divider lane each.
    localparam int NLANE = 9;

    // Pipeline stage numbers.
    localparam int ST_IN    = 0;
    localparam int ST_PROD  = 1;
    localparam int ST_COF   = 2;
    localparam int ST_DPROD = 3;
    localparam int ST_DET   = 4;
    localparam int ST_PREP  = 5;
    localparam int ST_OVF   = 6;
    localparam int ST_OUT   = ST_OVF + QW + 1;
    localparam int NSTAGE   = ST_OUT + 1;

    // Saturation codes.
    localparam logic [RES_W-1:0] SAT_POS = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] SAT_NEG = {1'b1, {(RES_W-1){1'b0}}};

    typedef logic [NSTAGE-1:0] stage_en_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] in_r1c1;
        logic signed [ELEM_W-1:0] in_r1c2;
        logic signed [ELEM_W-1:0] in_r1c3;
        logic signed [ELEM_W-1:0] in_r2c1;
        logic signed [ELEM_W-1:0] in_r2c2;
        logic signed [ELEM_W-1:0] in_r2c3;
        logic signed [ELEM_W-1:0] in_r3c1;
        logic signed [ELEM_W-1:0] in_r3c2;
        logic signed [ELEM_W-1:0] in_r3c3;
    } mat_beat_t;

    typedef struct packed {
        logic signed [RES_W-1:0] out_r1c1;
        logic signed [RES_W-1:0] out_r1c2;
        logic signed [RES_W-1:0] out_r1c3;
        logic signed [RES_W-1:0] out_r2c1;
        logic signed [RES_W-1:0] out_r2c2;
        logic signed [RES_W-1:0] out_r2c3;
        logic signed [RES_W-1:0] out_r3c1;
        logic signed [RES_W-1:0] out_r3c2;
        logic signed [RES_W-1:0] out_r3c3;
        logic                    singular;
    } nrm_beat_t;

endpackage

/* rtl/nmit_ctrl.sv */
// ----------------------------------------------------------------------------
// nmit_ctrl: pipeline flow control
// Valid bits of all stages and per-stage load enables; bubbles collapse.
// ----------------------------------------------------------------------------
module nmit_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output nmit_pkg::stage_en_t ld
);
    import nmit_pkg::*;

    stage_en_t valid_reg;
    stage_en_t valid_next;
    stage_en_t rdy;
    stage_en_t src_valid;

    // A stage may load when any stage at or after it is empty or the
    // output beat is being taken.
    for (genvar s = 0; s < NSTAGE; s++) begin : g_rdy
        assign rdy[s] = out_ready | ~(&valid_reg[NSTAGE-1:s]);
    end

    assign src_valid = {valid_reg[NSTAGE-2:0], in_valid};

    // Load only when the stage below holds a beat.
    assign ld         = rdy & src_valid;
    assign valid_next = (rdy & src_valid) | (~rdy & valid_reg);
    assign in_ready   = rdy[0];
    assign out_valid  = valid_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

/* rtl/nmit_front.sv */
// ----------------------------------------------------------------------------
// nmit_front: cofactors, determinant and divider operands
// Input register, products, cofactors, first-row expansion products,
// determinant, magnitudes and the singular decision, one stage each.
// ----------------------------------------------------------------------------
module nmit_front (
    input  logic                               clk,
    input  nmit_pkg::stage_en_t                ld,
    input  nmit_pkg::mat_beat_t                mat,
    input  logic [nmit_pkg::THR_W-1:0]         thr,
    output logic [nmit_pkg::NUM_W-1:0]         num [nmit_pkg::NLANE],
    output logic [nmit_pkg::DEN_W-1:0]         den,
    output logic                               neg [nmit_pkg::NLANE],
    output logic                               sing
);
    import nmit_pkg::*;

    logic signed [ELEM_W-1:0]  a_reg [3][3];
    logic signed [PROD_W-1:0]  prod_reg [18];
    logic signed [ELEM_W-1:0]  r0p_reg [3];
    logic signed [ELEM_W-1:0]  r0c_reg [3];
    logic signed [COF_W-1:0]   cof_reg [NLANE];
    logic signed [DPROD_W-1:0] dprod_reg [3];
    logic signed [COF_W-1:0]   cofd_reg [NLANE];
    logic signed [DET_W-1:0]   det_reg;
    logic signed [COF_W-1:0]   cofs_reg [NLANE];
    logic [NUM_W-1:0]          num_reg [NLANE];
    logic [DEN_W-1:0]          den_reg;
    logic                      neg_reg [NLANE];
    logic                      sing_reg;

    logic [DET_W-1:0]          det_mag;
    logic [DET_W-1:0]          thr_ext;

    // Input register.
    always_ff @(posedge clk)
    begin
        if (ld[ST_IN])
        begin
            a_reg[0][0] <= mat.in_r1c1;
            a_reg[0][1] <= mat.in_r1c2;
            a_reg[0][2] <= mat.in_r1c3;
            a_reg[1][0] <= mat.in_r2c1;
            a_reg[1][1] <= mat.in_r2c2;
            a_reg[1][2] <= mat.in_r2c3;
            a_reg[2][0] <= mat.in_r3c1;
            a_reg[2][1] <= mat.in_r3c2;
            a_reg[2][2] <= mat.in_r3c3;
        end
    end

    // Eighteen products; cofactor k is product 2k minus product 2k+1.
    always_ff @(posedge clk)
    begin
        if (ld[ST_PROD])
        begin
            prod_reg[0]  <= a_reg[1][1] * a_reg[2][2];
            prod_reg[1]  <= a_reg[2][1] * a_reg[1][2];
            prod_reg[2]  <= a_reg[1][2] * a_reg[2][0];
            prod_reg[3]  <= a_reg[1][0] * a_reg[2][2];
            prod_reg[4]  <= a_reg[1][0] * a_reg[2][1];
            prod_reg[5]  <= a_reg[1][1] * a_reg[2][0];
            prod_reg[6]  <= a_reg[0][2] * a_reg[2][1];
            prod_reg[7]  <= a_reg[0][1] * a_reg[2][2];
            prod_reg[8]  <= a_reg[0][0] * a_reg[2][2];
            prod_reg[9]  <= a_reg[0][2] * a_reg[2][0];
            prod_reg[10] <= a_reg[2][0] * a_reg[0][1];
            prod_reg[11] <= a_reg[0][0] * a_reg[2][1];
            prod_reg[12] <= a_reg[0][1] * a_reg[1][2];
            prod_reg[13] <= a_reg[0][2] * a_reg[1][1];
            prod_reg[14] <= a_reg[1][0] * a_reg[0][2];
            prod_reg[15] <= a_reg[0][0] * a_reg[1][2];
            prod_reg[16] <= a_reg[0][0] * a_reg[1][1];
            prod_reg[17] <= a_reg[1][0] * a_reg[0][1];
            for (int j = 0; j < 3; j++)
            begin
                r0p_reg[j] <= a_reg[0][j];
            end
        end
    end

    // Cofactors.
    always_ff @(posedge clk)
    begin
        if (ld[ST_COF])
        begin
            for (int k = 0; k < NLANE; k++)
            begin
                cof_reg[k] <= COF_W'(prod_reg[2*k]) - COF_W'(prod_reg[2*k+1]);
            end
            for (int j = 0; j < 3; j++)
            begin
                r0c_reg[j] <= r0p_reg[j];
            end
        end
    end

    // First-row expansion products.
    always_ff @(posedge clk)
    begin
        if (ld[ST_DPROD])
        begin
            for (int j = 0; j < 3; j++)
            begin
                dprod_reg[j] <= DPROD_W'(r0c_reg[j]) * DPROD_W'(cof_reg[j]);
            end
            cofd_reg <= cof_reg;
        end
    end

    // Determinant.
    always_ff @(posedge clk)
    begin
        if (ld[ST_DET])
        begin
            det_reg  <= DET_W'(dprod_reg[0]) + DET_W'(dprod_reg[1])
                      + DET_W'(dprod_reg[2]);
            cofs_reg <= cofd_reg;
        end
    end

    // Magnitudes, divider operands and the singular decision.
    assign det_mag = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
    assign thr_ext = DET_W'({thr, {THR_SH{1'b0}}});

    always_ff @(posedge clk)
    begin
        logic [COF_W-1:0] cmag;
        if (ld[ST_PREP])
        begin
            for (int k = 0; k < NLANE; k++)
            begin
                cmag = cofs_reg[k][COF_W-1] ? COF_W'(-cofs_reg[k]) : COF_W'(cofs_reg[k]);
                num_reg[k] <= NUM_W'({cmag[CMAG_W-1:0], {NUM_SH{1'b0}}})
                            + NUM_W'(det_mag[DMAG_W-1:0]);
                neg_reg[k] <= cofs_reg[k][COF_W-1] ^ det_reg[DET_W-1];
            end
            den_reg  <= {det_mag[DMAG_W-1:0], 1'b0};
            sing_reg <= (det_mag == '0) || (det_mag < thr_ext);
        end
    end

    assign num  = num_reg;
    assign den  = den_reg;
    assign neg  = neg_reg;
    assign sing = sing_reg;

endmodule

/* rtl/nmit_lane.sv */
// ----------------------------------------------------------------------------
// nmit_lane: pipelined rounding divider for one matrix element
// An overflow check, then one restoring quotient bit per stage, then
// saturation of the signed Q16.16 result.
// ----------------------------------------------------------------------------
module nmit_lane (
    input  logic                        clk,
    input  nmit_pkg::stage_en_t         ld,
    input  logic [nmit_pkg::NUM_W-1:0]  num,
    input  logic [nmit_pkg::DEN_W-1:0]  den,
    input  logic                        neg,
    output logic [nmit_pkg::RES_W-1:0]  result
);
    import nmit_pkg::*;

    logic [DEN_W-1:0] rem_reg [QW+1];
    logic [QW-1:0]    low_reg [QW+1];
    logic [QW-1:0]    quo_reg [QW+1];
    logic [DEN_W-1:0] den_reg [QW+1];
    logic             ovf_reg [QW+1];
    logic             neg_reg [QW+1];

    // Quotients of 2^32 or more saturate; the rest start with a partial
    // remainder below the divisor.
    always_ff @(posedge clk)
    begin
        if (ld[ST_OVF])
        begin
            rem_reg[0] <= DEN_W'(num[NUM_W-1:QW]);
            low_reg[0] <= num[QW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= DEN_W'(num[NUM_W-1:QW]) >= den;
            neg_reg[0] <= neg;
        end
    end

    // One quotient bit per stage.
    for (genvar j = 1; j <= QW; j++) begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[j-1], low_reg[j-1][QW-1]};
        assign diff  = trial - {1'b0, den_reg[j-1]};
        assign ge    = !diff[DEN_W];

        always_ff @(posedge clk)
        begin
            if (ld[ST_OVF+j])
            begin
                rem_reg[j] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                low_reg[j] <= {low_reg[j-1][QW-2:0], 1'b0};
                quo_reg[j] <= {quo_reg[j-1][QW-2:0], ge};
                den_reg[j] <= den_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    // Sign and saturation.
    always_comb
    begin
        logic [QW-1:0] q;
        q = quo_reg[QW];
        if (ovf_reg[QW])
        begin
            result = neg_reg[QW] ? SAT_NEG : SAT_POS;
        end
        else if (q == '0)
        begin
            result = '0;
        end
        else if (q[QW-1])
        begin
            result = neg_reg[QW] ? SAT_NEG : SAT_POS;
        end
        else
        begin
            result = neg_reg[QW] ? RES_W'(-q) : q;
        end
    end

endmodule

/* rtl/normal_matrix_inverse_transpose_top.sv */
// ----------------------------------------------------------------------------
// normal_matrix_inverse_transpose_top: normal matrix of a 3x3 transform
// Inverse-transpose of a Q4.12 matrix as Q16.16 elements, nine divider lanes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (mat_valid, mat_ready, mat) carries one matrix per beat.
//   The output channel (nrm_valid, nrm_ready, nrm) carries the nine normal
//   matrix elements and the singular flag. A matrix whose determinant is zero
//   or smaller in magnitude than the threshold gives singular set and zeros.
//   cfg_we and cfg_data write the threshold, in units of 2^-24, while idle.
// Pipeline:
//   One matrix enters every cycle unless every stage holds a beat and the
//   output is stalled. The depth is set by the nine divider lanes, which
//   resolve one quotient bit per stage over 32 stages after a six-stage
//   determinant front end and an overflow check, followed by the output
//   register.
// Reset:
//   All stages empty, threshold 168.
// Stalls:
//   When nrm_ready is low the result holds; empty stages further down still
//   fill, so mat_ready drops only when every stage holds a beat.
// ----------------------------------------------------------------------------
module normal_matrix_inverse_transpose_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         mat_valid,
    output logic                         mat_ready,
    input  nmit_pkg::mat_beat_t          mat,
    output logic                         nrm_valid,
    input  logic                         nrm_ready,
    output nmit_pkg::nrm_beat_t          nrm,
    input  logic                         cfg_we,
    input  logic [nmit_pkg::THR_W-1:0]   cfg_data
);
    import nmit_pkg::*;

    stage_en_t        ld;
    logic [THR_W-1:0] thr_reg;
    logic [NUM_W-1:0] num [NLANE];
    logic [DEN_W-1:0] den;
    logic             neg [NLANE];
    logic             sing;
    logic [RES_W-1:0] lane_res [NLANE];
    logic             sing_reg [QW+1];
    nrm_beat_t        nrm_reg;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(THR_RESET);
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    nmit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .out_valid (nrm_valid),
        .out_ready (nrm_ready),
        .ld        (ld)
    );

    nmit_front u_front (
        .clk  (clk),
        .ld   (ld),
        .mat  (mat),
        .thr  (thr_reg),
        .num  (num),
        .den  (den),
        .neg  (neg),
        .sing (sing)
    );

    for (genvar k = 0; k < NLANE; k++) begin : g_lane
        nmit_lane u_lane (
            .clk    (clk),
            .ld     (ld),
            .num    (num[k]),
            .den    (den),
            .neg    (neg[k]),
            .result (lane_res[k])
        );
    end

    // Singular flag travels beside the divider stages.
    for (genvar j = 0; j <= QW; j++) begin : g_sing
        always_ff @(posedge clk)
        begin
            if (ld[ST_OVF+j])
            begin
                sing_reg[j] <= (j == 0) ? sing : sing_reg[(j == 0) ? 0 : j-1];
            end
        end
    end

    // Merge the lanes into the output beat.
    always_ff @(posedge clk)
    begin
        if (ld[ST_OUT])
        begin
            nrm_reg.out_r1c1 <= sing_reg[QW] ? '0 : lane_res[0];
            nrm_reg.out_r1c2 <= sing_reg[QW] ? '0 : lane_res[1];
            nrm_reg.out_r1c3 <= sing_reg[QW] ? '0 : lane_res[2];
            nrm_reg.out_r2c1 <= sing_reg[QW] ? '0 : lane_res[3];
            nrm_reg.out_r2c2 <= sing_reg[QW] ? '0 : lane_res[4];
            nrm_reg.out_r2c3 <= sing_reg[QW] ? '0 : lane_res[5];
            nrm_reg.out_r3c1 <= sing_reg[QW] ? '0 : lane_res[6];
            nrm_reg.out_r3c2 <= sing_reg[QW] ? '0 : lane_res[7];
            nrm_reg.out_r3c3 <= sing_reg[QW] ? '0 : lane_res[8];
            nrm_reg.singular <= sing_reg[QW];
        end
    end

    assign nrm = nrm_reg;

endmodule

/* rtl/nmit_checker.sv */
// ----------------------------------------------------------------------------
// nmit_checker: port-level checks of the normal matrix unit
// Output hold under stall, singular beats and input flow, bound to the top.
// ----------------------------------------------------------------------------
module nmit_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                mat_ready,
    input logic                nrm_valid,
    input logic                nrm_ready,
    input nmit_pkg::nrm_beat_t nrm
);
    import nmit_pkg::*;

    // A stalled output beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_valid && !nrm_ready |=> nrm_valid && $stable(nrm))
        else $error("output beat changed while stalled");

    // A singular beat carries only zero elements.
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_valid && nrm.singular |->
            nrm.out_r1c1 == 0 && nrm.out_r1c2 == 0 && nrm.out_r1c3 == 0 &&
            nrm.out_r2c1 == 0 && nrm.out_r2c2 == 0 && nrm.out_r2c3 == 0 &&
            nrm.out_r3c1 == 0 && nrm.out_r3c2 == 0 && nrm.out_r3c3 == 0)
        else $error("singular beat with nonzero element");

    // Input is refused only while the output beat is stalled.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !nrm_valid || nrm_ready |-> mat_ready)
        else $error("input refused with room in the pipeline");

    // Nothing leaves the cycle after reset is released.
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !nrm_valid)
        else $error("output beat right after reset");

endmodule

bind normal_matrix_inverse_transpose_top nmit_checker u_nmit_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat_ready (mat_ready),
    .nrm_valid (nrm_valid),
    .nrm_ready (nrm_ready),
    .nrm       (nrm)
);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Normal matrix unit testbench
// Drives 3x3 Q4.12 matrices through the valid/ready input, predicts each
// inverse-transpose beat with an exact integer model and compares every
// result beat field by field, under several thresholds and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nmit_pkg::*;

    localparam int LATENCY    = 40;
    localparam int STALL_LIMIT = 5000;

    logic                clk;
    logic                rst_n;
    logic                mat_valid;
    logic                mat_ready;
    mat_beat_t           mat;
    logic                nrm_valid;
    logic                nrm_ready;
    nrm_beat_t           nrm;
    logic                cfg_we;
    logic [THR_W-1:0]    cfg_data;

    // Predictor copy of the threshold and the store of expected beats.
    logic [THR_W-1:0]    model_threshold;
    nrm_beat_t           normal_queue[$];
    int                  error_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  quiet_cycles;

    normal_matrix_inverse_transpose_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_ready (mat_ready),
        .mat       (mat),
        .nrm_valid (nrm_valid),
        .nrm_ready (nrm_ready),
        .nrm       (nrm),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Rounded, saturated Q16.16 quotient of a cofactor by the determinant.
    function automatic logic [RES_W-1:0] q16_quotient(longint cof, longint det);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        logic         neg;
        num = 128'(cof < 0 ? -cof : cof) << 28;
        den = 128'(det < 0 ? -det : det);
        q = (2 * num + den) / (2 * den);
        neg = (cof < 0) != (det < 0);
        if (q == 0)
            return '0;
        if (neg)
        begin
            if (q >= 128'h8000_0000)
                return SAT_NEG;
            return RES_W'(-q);
        end
        if (q > 128'h7FFF_FFFF)
            return SAT_POS;
        return RES_W'(q);
    endfunction

    // Expected normal matrix of one input beat.
    function automatic nrm_beat_t normal_of(mat_beat_t m);
        longint    a[3][3];
        longint    c[3][3];
        longint    det;
        longint    mag;
        nrm_beat_t r;
        a[0][0] = m.in_r1c1; a[0][1] = m.in_r1c2; a[0][2] = m.in_r1c3;
        a[1][0] = m.in_r2c1; a[1][1] = m.in_r2c2; a[1][2] = m.in_r2c3;
        a[2][0] = m.in_r3c1; a[2][1] = m.in_r3c2; a[2][2] = m.in_r3c3;
        c[0][0] =   a[1][1] * a[2][2] - a[2][1] * a[1][2];
        c[0][1] = -(a[1][0] * a[2][2] - a[1][2] * a[2][0]);
        c[0][2] =   a[1][0] * a[2][1] - a[1][1] * a[2][0];
        c[1][0] = -(a[0][1] * a[2][2] - a[0][2] * a[2][1]);
        c[1][1] =   a[0][0] * a[2][2] - a[0][2] * a[2][0];
        c[1][2] = -(a[0][0] * a[2][1] - a[2][0] * a[0][1]);
        c[2][0] =   a[0][1] * a[1][2] - a[0][2] * a[1][1];
        c[2][1] = -(a[0][0] * a[1][2] - a[1][0] * a[0][2]);
        c[2][2] =   a[0][0] * a[1][1] - a[1][0] * a[0][1];
        det = a[0][0] * c[0][0] + a[0][1] * c[0][1] + a[0][2] * c[0][2];
        mag = det < 0 ? -det : det;
        r = '0;
        if (det == 0 || mag < (longint'(model_threshold) << THR_SH))
        begin
            r.singular = 1'b1;
            return r;
        end
        r.out_r1c1 = q16_quotient(c[0][0], det);
        r.out_r1c2 = q16_quotient(c[0][1], det);
        r.out_r1c3 = q16_quotient(c[0][2], det);
        r.out_r2c1 = q16_quotient(c[1][0], det);
        r.out_r2c2 = q16_quotient(c[1][1], det);
        r.out_r2c3 = q16_quotient(c[1][2], det);
        r.out_r3c1 = q16_quotient(c[2][0], det);
        r.out_r3c2 = q16_quotient(c[2][1], det);
        r.out_r3c3 = q16_quotient(c[2][2], det);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [RES_W-1:0] got,
                                   logic [RES_W-1:0] want);
        error_count++;
        $display("%0t MISMATCH %s: got %h expected %h", $realtime, what, got, want);
    endtask

    // Send one matrix beat, holding it until accepted. Valid drops only
    // while the sender idles or when the stream is drained.
    task automatic send_matrix(mat_beat_t m);
        while ($urandom_range(99) < send_idle_pct)
        begin
            mat_valid <= 1'b0;
            @(negedge clk);
        end
        mat_valid <= 1'b1;
        mat <= m;
        @(posedge clk);
        while (!mat_ready)
            @(posedge clk);
        normal_queue.push_back(normal_of(m));
        @(negedge clk);
    endtask

    // Receiver: random back-pressure and field by field comparison.
    always @(negedge clk)
        nrm_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        nrm_beat_t want;
        if (rst_n && nrm_valid && nrm_ready)
        begin
            if (normal_queue.size() == 0)
            begin
                report_mismatch("unexpected beat", nrm.out_r1c1, '0);
            end
            else
            begin
                want = normal_queue.pop_front();
                if (nrm.out_r1c1 !== want.out_r1c1) report_mismatch("r1c1", nrm.out_r1c1, want.out_r1c1);
                if (nrm.out_r1c2 !== want.out_r1c2) report_mismatch("r1c2", nrm.out_r1c2, want.out_r1c2);
                if (nrm.out_r1c3 !== want.out_r1c3) report_mismatch("r1c3", nrm.out_r1c3, want.out_r1c3);
                if (nrm.out_r2c1 !== want.out_r2c1) report_mismatch("r2c1", nrm.out_r2c1, want.out_r2c1);
                if (nrm.out_r2c2 !== want.out_r2c2) report_mismatch("r2c2", nrm.out_r2c2, want.out_r2c2);
                if (nrm.out_r2c3 !== want.out_r2c3) report_mismatch("r2c3", nrm.out_r2c3, want.out_r2c3);
                if (nrm.out_r3c1 !== want.out_r3c1) report_mismatch("r3c1", nrm.out_r3c1, want.out_r3c1);
                if (nrm.out_r3c2 !== want.out_r3c2) report_mismatch("r3c2", nrm.out_r3c2, want.out_r3c2);
                if (nrm.out_r3c3 !== want.out_r3c3) report_mismatch("r3c3", nrm.out_r3c3, want.out_r3c3);
                if (nrm.singular !== want.singular)
                    report_mismatch("singular", RES_W'(nrm.singular), RES_W'(want.singular));
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge clk)
    begin
        if ((mat_valid && mat_ready) || (nrm_valid && nrm_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stop sending, wait until all expected beats are out, then let the
    // pipe settle.
    task automatic drain();
        mat_valid <= 1'b0;
        while (normal_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        model_threshold = value;
    endtask

    function automatic mat_beat_t diag(logic signed [ELEM_W-1:0] d1,
                                       logic signed [ELEM_W-1:0] d2,
                                       logic signed [ELEM_W-1:0] d3);
        mat_beat_t m;
        m = '0;
        m.in_r1c1 = d1;
        m.in_r2c2 = d2;
        m.in_r3c3 = d3;
        return m;
    endfunction

    // Random element: mostly moderate, sometimes full range or extremes.
    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            1, 2, 3: return 16'($urandom);
            4: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($signed($urandom_range(16384)) - 8192);
        endcase
    endfunction

    function automatic mat_beat_t rand_matrix();
        mat_beat_t m;
        m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
             rand_elem(), rand_elem(), rand_elem(), rand_elem()};
        // Sometimes make row 3 a copy of row 1 to hit exact singularity.
        if ($urandom_range(15) == 0)
        begin
            m.in_r3c1 = m.in_r1c1;
            m.in_r3c2 = m.in_r1c2;
            m.in_r3c3 = m.in_r1c3;
        end
        return m;
    endfunction

    // Directed identity, scaling, extremes, singular and saturation cases.
    task automatic test_directed();
        mat_beat_t m;
        send_matrix(diag(16'sd4096, 16'sd4096, 16'sd4096));
        send_matrix(diag(-16'sd4096, 16'sd8192, 16'sd2048));
        send_matrix(diag(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_matrix(diag(16'sh8000, 16'sh8000, 16'sh8000));
        send_matrix(diag(16'sh8000, 16'sh7FFF, 16'sh8000));
        send_matrix('0);
        send_matrix({9{16'sh7FFF}});
        send_matrix({9{16'sh8000}});
        send_matrix({9{16'hFFFF}});
        send_matrix(diag(16'sd1, 16'sd1, 16'sd1));
        send_matrix(diag(16'sd64, 16'sd64, 16'sd64));
        send_matrix(diag(16'sd16, 16'sd16, 16'sd16));
        send_matrix(diag(16'sd1, 16'sh7FFF, 16'sh7FFF));
        send_matrix(diag(16'sd1, 16'sh8000, 16'sh7FFF));
        m = diag(16'sd4096, 16'sd4096, 16'sd4096);
        m.in_r1c2 = 16'sh7FFF;
        m.in_r2c3 = 16'sh8000;
        send_matrix(m);
        m = diag(16'sd3, 16'sd5, 16'sd7);
        m.in_r3c1 = 16'sd2;
        send_matrix(m);
        m = {16'sh5555, 16'shAAAA, 16'sh0F0F, 16'shF0F0, 16'sh3333,
             16'shCCCC, 16'sh00FF, 16'shFF00, 16'sh1234};
        send_matrix(m);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_matrix(rand_matrix());
    endtask

    task automatic test_thresholds();
        write_threshold('0);
        send_matrix(diag(16'sd1, 16'sd1, 16'sd1));
        test_random(150);
        write_threshold({THR_W{1'b1}});
        send_matrix(diag(16'sh8000, 16'sh8000, 16'sh8000));
        test_random(100);
        write_threshold(31'd1 << 30);
        test_random(100);
        write_threshold(31'($urandom_range(1 << 20)));
        test_random(150);
        write_threshold(31'd168);
    endtask

    initial
    begin
        rst_n = 1'b0;
        mat_valid = 1'b0;
        mat = '0;
        nrm_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        model_threshold = THR_W'(THR_RESET);
        error_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 23;
        recv_idle_pct = 46;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(450);
        send_idle_pct = 46;
        recv_idle_pct = 23;
        test_thresholds();
        test_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(700);
        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
